// ===== rtl/motor_throttle_slew_limiter_assert.svh =====
// assertion macros for the throttle slew limiter
// expects clk_i and rst_ni in the scope of each use
`ifndef MOTOR_THROTTLE_SLEW_LIMITER_ASSERT_SVH
`define MOTOR_THROTTLE_SLEW_LIMITER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// shared types, constants and helper functions of the throttle slew limiter
// no dependencies
package mts_pkg;

  // field widths
  localparam int PORT_W     = 2;
  localparam int THR_W      = 8;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 16;
  localparam int MASK_W     = 4;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_PORTS_DEF = 4;

  // ramp timing and soft start thresholds
  localparam logic [THR_W-1:0]  SMALL_MAG       = 8'd20;
  localparam logic [TIME_W-1:0] MIN_INTERVAL_US = 32'd100000;

  // reach = rate * dt, and its scaling by one second
  localparam int REACH_W = RATE_W + TIME_W;
  localparam int SCALE_W = 20;
  localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
  // reach below 2^28 covers every case where a partial step is taken
  localparam int QUOT_W = 28;
  // exact floor(x / 1e6) for x < 2^28: (x * ceil(2^48 / 1e6)) >> 48
  localparam int RECIP_SHIFT = 48;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd281474977;
  localparam int PROD_W = QUOT_W + RECIP_W;

  // register reset values
  localparam logic [RATE_W-1:0] RATE_RESET   = 16'd100;
  localparam logic [MASK_W-1:0] SOFT_RESET   = 4'h0;
  localparam logic [MASK_W-1:0] NORMAL_RESET = 4'hF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_RATE   = 2'd0,
    CFG_SOFT_START  = 2'd1,
    CFG_NORMAL_MODE = 2'd2
  } mts_cfg_idx_e;

  typedef struct packed {
    logic [RATE_W-1:0] ramp_rate;
    logic [MASK_W-1:0] soft_start_mask;
    logic [MASK_W-1:0] normal_mode_mask;
  } mts_cfg_t;

  // one entry of the per-port state memory
  typedef struct packed {
    logic signed [THR_W-1:0] prior;
    logic signed [THR_W-1:0] held;
    logic signed [THR_W-1:0] applied;
    logic                    ramping;
    logic [TIME_W-1:0]       last_us;
  } mts_state_t;

  // magnitude of a signed throttle, 0..128
  function automatic logic [THR_W-1:0] mts_mag(logic signed [THR_W-1:0] v);
    logic [THR_W-1:0] m;
    m = v[THR_W-1] ? (~v + 8'd1) : v;
    return m;
  endfunction

  // mag*255/127 = 2*mag + (mag >= 127), saturated at 255
  function automatic logic [DUTY_W-1:0] mts_duty(logic [THR_W-1:0] m);
    logic [DUTY_W:0] d;
    d = {m, 1'b0} + {8'd0, (m >= 8'd127)};
    return d[DUTY_W] ? 8'hFF : d[DUTY_W-1:0];
  endfunction

endpackage

// ===== rtl/mts_state_mem.sv =====
// per-port state memory with registered read and reset-cleared valid flags
// depends on mts_pkg
module mts_state_mem import mts_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output mts_state_t      rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  mts_state_t      wr_data_i
);

  mts_state_t           mem_q [NUM_PORTS];
  mts_state_t           rd_q;
  logic                 rd_valid_q;
  logic [NUM_PORTS-1:0] valid_q;

  // storage array, read-before-write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // entry valid flags, an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/mts_slew_pipe.sv =====
// four-stage read-modify-write pipeline: ramp decision, step math, drive output
// depends on mts_pkg, mts_state_mem ports and motor_throttle_slew_limiter_assert.svh
`include "motor_throttle_slew_limiter_assert.svh"

module mts_slew_pipe import mts_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mts_cfg_t                 cfg_i,
  // input transaction
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [PORT_W-1:0]        port_i,
  input  logic signed [THR_W-1:0]  throttle_i,
  input  logic [TIME_W-1:0]        time_us_i,
  // state memory
  output logic                     rd_en_o,
  output logic [IdxW-1:0]          rd_addr_o,
  input  mts_state_t               rd_data_i,
  output logic                     wr_en_o,
  output logic [IdxW-1:0]          wr_addr_o,
  output mts_state_t               wr_data_o,
  // result transaction
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PORT_W-1:0]        out_port_o,
  output logic                     drive_update_o,
  output logic                     reverse_o,
  output logic [DUTY_W-1:0]        duty_o
);

  // stage valids and handshake
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
  logic hazard, in_acc;

  // stage 1: item and memory read data
  logic [PORT_W-1:0]       s1_port_q;
  logic signed [THR_W-1:0] s1_thr_q;
  logic [TIME_W-1:0]       s1_now_q;
  mts_state_t              s1_st;
  logic                    s1_port_ok, s1_active, s1_changed, s1_reversal, s1_small;
  logic                    s1_ramp;
  logic signed [THR_W-1:0] s1_held;
  logic [TIME_W-1:0]       s1_dt;
  logic [THR_W:0]          s1_diff, s1_diff_abs;

  // stage 2
  logic [PORT_W-1:0]       s2_port_q;
  logic signed [THR_W-1:0] s2_thr_q, s2_held_q, s2_applied_q;
  logic [TIME_W-1:0]       s2_now_q, s2_last_q, s2_dt_q;
  logic                    s2_port_ok_q, s2_active_q, s2_ramp_q, s2_neg_q;
  logic [THR_W-1:0]        s2_abs_q;
  logic [REACH_W-1:0]      s2_reach;
  logic [QUOT_W-1:0]       s2_scaled;
  logic                    s2_early;

  // stage 3
  logic [PORT_W-1:0]       s3_port_q;
  logic signed [THR_W-1:0] s3_thr_q, s3_held_q, s3_applied_q;
  logic [TIME_W-1:0]       s3_now_q, s3_last_q;
  logic                    s3_port_ok_q, s3_active_q, s3_ramp_q, s3_neg_q, s3_early_q;
  logic [REACH_W-1:0]      s3_reach_q;
  logic [QUOT_W-1:0]       s3_scaled_q;
  logic                    s3_within;
  logic [PROD_W-1:0]       s3_prod;

  // stage 4
  logic [PORT_W-1:0]       s4_port_q;
  logic signed [THR_W-1:0] s4_thr_q, s4_held_q, s4_applied_q;
  logic [TIME_W-1:0]       s4_now_q, s4_last_q;
  logic                    s4_port_ok_q, s4_active_q, s4_ramp_q, s4_neg_q, s4_early_q;
  logic                    s4_within_q;
  logic [THR_W-1:0]        s4_step_q;
  logic [THR_W+1:0]        s4_app_ext, s4_sum;
  logic signed [THR_W-1:0] s4_drive_val, s4_new_held;
  logic                    s4_upd, s4_wr, s4_new_ramp;
  mts_state_t              s4_new_st;

  // output register
  logic [PORT_W-1:0] out_port_q;
  logic              out_upd_q, out_rev_q;
  logic [DUTY_W-1:0] out_duty_q;

  // ready chain, each stage moves when the next one frees up
  assign out_ready = !out_v_q || !out_stall_i;
  assign s4_ready  = !s4_v_q || out_ready;
  assign s3_ready  = !s3_v_q || s4_ready;
  assign s2_ready  = !s2_v_q || s3_ready;
  assign s1_ready  = !s1_v_q || s2_ready;

  // interlock: one transaction per port in flight until its write-back
  assign hazard = (s1_v_q && (s1_port_q == port_i)) || (s2_v_q && (s2_port_q == port_i)) ||
                  (s3_v_q && (s3_port_q == port_i)) || (s4_v_q && (s4_port_q == port_i));
  assign in_stall_o = !s1_ready || hazard;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_en_o    = in_acc;
  assign rd_addr_o  = IdxW'(port_i);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_acc;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_ready) begin
        s4_v_q <= s3_v_q;
      end
      if (out_ready) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // stage 1: setpoint change, ramp start and elapsed time
  assign s1_st       = rd_data_i;
  assign s1_port_ok  = (32'(s1_port_q) < NUM_PORTS);
  assign s1_active   = s1_port_ok && cfg_i.normal_mode_mask[s1_port_q] &&
                       cfg_i.soft_start_mask[s1_port_q];
  assign s1_changed  = (s1_st.prior != s1_thr_q);
  assign s1_small    = (mts_mag(s1_st.prior) <= SMALL_MAG) || (mts_mag(s1_thr_q) <= SMALL_MAG);
  assign s1_reversal = (!s1_thr_q[THR_W-1] && (s1_thr_q != 0) && s1_st.prior[THR_W-1]) ||
                       (s1_thr_q[THR_W-1] && !s1_st.prior[THR_W-1] && (s1_st.prior != 0));
  assign s1_ramp     = s1_st.ramping || (s1_changed && (s1_small || s1_reversal));
  assign s1_held     = s1_changed ? s1_thr_q : s1_st.held;
  assign s1_dt       = s1_now_q - s1_st.last_us;
  assign s1_diff     = {s1_thr_q[THR_W-1], s1_thr_q} - {s1_st.applied[THR_W-1], s1_st.applied};
  assign s1_diff_abs = s1_diff[THR_W] ? (~s1_diff + 9'd1) : s1_diff;

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_port_q <= port_i;
      s1_thr_q  <= throttle_i;
      s1_now_q  <= time_us_i;
    end
    if (s2_ready) begin
      s2_port_q    <= s1_port_q;
      s2_thr_q     <= s1_thr_q;
      s2_now_q     <= s1_now_q;
      s2_port_ok_q <= s1_port_ok;
      s2_active_q  <= s1_active;
      s2_ramp_q    <= s1_ramp;
      s2_held_q    <= s1_held;
      s2_applied_q <= s1_st.applied;
      s2_last_q    <= s1_st.last_us;
      s2_dt_q      <= s1_dt;
      s2_neg_q     <= s1_diff[THR_W];
      s2_abs_q     <= s1_diff_abs[THR_W-1:0];
    end
  end

  // stage 2: reach = rate * dt, distance scaled to microseconds
  assign s2_reach  = REACH_W'(cfg_i.ramp_rate) * REACH_W'(s2_dt_q);
  assign s2_scaled = QUOT_W'(s2_abs_q) * QUOT_W'(US_PER_S);
  assign s2_early  = (s2_dt_q < MIN_INTERVAL_US);

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_port_q    <= s2_port_q;
      s3_thr_q     <= s2_thr_q;
      s3_now_q     <= s2_now_q;
      s3_port_ok_q <= s2_port_ok_q;
      s3_active_q  <= s2_active_q;
      s3_ramp_q    <= s2_ramp_q;
      s3_held_q    <= s2_held_q;
      s3_applied_q <= s2_applied_q;
      s3_last_q    <= s2_last_q;
      s3_neg_q     <= s2_neg_q;
      s3_reach_q   <= s2_reach;
      s3_scaled_q  <= s2_scaled;
      s3_early_q   <= s2_early;
    end
  end

  // stage 3: within-reach test and reciprocal multiply for the step size
  assign s3_within = (s3_reach_q >= REACH_W'(s3_scaled_q));
  assign s3_prod   = PROD_W'(s3_reach_q[QUOT_W-1:0]) * PROD_W'(RECIP_MUL);

  always_ff @(posedge clk_i) begin
    if (s4_ready) begin
      s4_port_q    <= s3_port_q;
      s4_thr_q     <= s3_thr_q;
      s4_now_q     <= s3_now_q;
      s4_port_ok_q <= s3_port_ok_q;
      s4_active_q  <= s3_active_q;
      s4_ramp_q    <= s3_ramp_q;
      s4_held_q    <= s3_held_q;
      s4_applied_q <= s3_applied_q;
      s4_last_q    <= s3_last_q;
      s4_neg_q     <= s3_neg_q;
      s4_early_q   <= s3_early_q;
      s4_within_q  <= s3_within;
      s4_step_q    <= s3_prod[RECIP_SHIFT+THR_W-1:RECIP_SHIFT];
    end
  end

  // stage 4: step toward the setpoint, pick the drive value, build write-back
  assign s4_app_ext = {{2{s4_applied_q[THR_W-1]}}, s4_applied_q};
  assign s4_sum     = s4_neg_q ? (s4_app_ext - {2'b00, s4_step_q}) :
                                 (s4_app_ext + {2'b00, s4_step_q});

  always_comb begin
    s4_upd       = 1'b0;
    s4_wr        = 1'b0;
    s4_drive_val = '0;
    s4_new_held  = s4_held_q;
    s4_new_ramp  = s4_ramp_q;
    s4_new_st    = '{prior: s4_thr_q, held: s4_held_q, applied: s4_applied_q,
                     ramping: s4_ramp_q, last_us: s4_last_q};
    if (!s4_port_ok_q) begin
      s4_upd = 1'b0;
    end else if (!s4_active_q) begin
      s4_upd       = 1'b1;
      s4_drive_val = s4_thr_q;
    end else begin
      s4_wr = 1'b1;
      if (!(s4_ramp_q && s4_early_q)) begin
        if (s4_ramp_q && (cfg_i.ramp_rate != '0)) begin
          if (s4_within_q) begin
            s4_new_held = s4_thr_q;
            s4_new_ramp = 1'b0;
          end else begin
            s4_new_held = s4_sum[THR_W-1:0];
          end
        end
        s4_upd            = 1'b1;
        s4_drive_val      = s4_ramp_q ? s4_new_held : s4_thr_q;
        s4_new_st.held    = s4_new_held;
        s4_new_st.ramping = s4_new_ramp;
        s4_new_st.applied = s4_new_held;
        s4_new_st.last_us = s4_now_q;
      end
    end
  end

  assign wr_en_o   = s4_v_q && out_ready && s4_wr;
  assign wr_addr_o = IdxW'(s4_port_q);
  assign wr_data_o = s4_new_st;

  // output register
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_port_q <= s4_port_q;
      out_upd_q  <= s4_upd;
      out_rev_q  <= s4_upd && !(!s4_drive_val[THR_W-1] && (s4_drive_val != 0));
      out_duty_q <= s4_upd ? mts_duty(mts_mag(s4_drive_val)) : '0;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_port_o     = out_port_q;
  assign drive_update_o = out_upd_q;
  assign reverse_o      = out_rev_q;
  assign duty_o         = out_duty_q;

  // checks
  `MTS_ASSERT_IMPLY(a_port_interlock, s1_v_q && s2_v_q, s1_port_q != s2_port_q, "same port in adjacent stages")
  `MTS_ASSERT_NEXT(a_write_with_result, wr_en_o, out_v_q, "state write-back without a result")
  `MTS_ASSERT_IMPLY(a_no_update_zero, out_v_q && !out_upd_q, (out_duty_q == '0) && !out_rev_q, "held drive reports nonzero fields")

endmodule

// ===== rtl/motor_throttle_slew_limiter.sv =====
// top level of the throttle slew limiter: configuration registers, state memory, pipeline
// depends on mts_pkg, mts_state_mem and mts_slew_pipe
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------------------
//   in      | in_valid_i / in_stall_o    | port_i, throttle_i, time_us_i
//   out     | out_valid_o / out_stall_i  | out_port_o, drive_update_o, reverse_o, duty_o
//   cfg     | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// a transaction passes stage 1 (loaded at the accepting edge), stages 2 to 4 and the
// output register before it shows at the output; transactions for different ports are
// taken every cycle while the output does not stall
// a port has one transaction in flight at a time: the state memory read-modify-write
// spans stages 1 to 4, so a repeated port waits until the previous write-back
// state entries read as zero until first written, so no clearing pass follows reset
// a stalled result holds in the output register while the stages behind it keep filling
module motor_throttle_slew_limiter import mts_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PORT_W-1:0]       port_i,
  input  logic signed [THR_W-1:0] throttle_i,
  input  logic [TIME_W-1:0]       time_us_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PORT_W-1:0]       out_port_o,
  output logic                    drive_update_o,
  output logic                    reverse_o,
  output logic [DUTY_W-1:0]       duty_o
);

  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  mts_cfg_t        cfg_d, cfg_q;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  mts_state_t      rd_data, wr_data;

  // register decode, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mts_cfg_idx_e'(cfg_idx_i))
        CFG_RAMP_RATE:   cfg_d.ramp_rate        = cfg_wdata_i[RATE_W-1:0];
        CFG_SOFT_START:  cfg_d.soft_start_mask  = cfg_wdata_i[MASK_W-1:0];
        CFG_NORMAL_MODE: cfg_d.normal_mode_mask = cfg_wdata_i[MASK_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ramp_rate: RATE_RESET, soft_start_mask: SOFT_RESET,
                 normal_mode_mask: NORMAL_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // per-port state
  mts_state_mem #(
    .NUM_PORTS (NUM_PORTS)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // ramp pipeline
  mts_slew_pipe #(
    .NUM_PORTS (NUM_PORTS)
  ) u_slew_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .port_i         (port_i),
    .throttle_i     (throttle_i),
    .time_us_i      (time_us_i),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_port_o     (out_port_o),
    .drive_update_o (drive_update_o),
    .reverse_o      (reverse_o),
    .duty_o         (duty_o)
  );

endmodule

// ===== dv/motor_throttle_slew_limiter_tb.sv =====
// self-checking testbench for motor_throttle_slew_limiter
// depends on mts_pkg and the slew limiter rtl; predicts each drive result per port
`timescale 1ns / 100ps

module testbench;
  import mts_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_OFF_LEN  = 200;
  localparam int SOFT_BAND     = 20;
  localparam int PORT_COUNT    = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [TIME_W-1:0] MIN_GAP_US = 32'd100000;
  localparam longint unsigned US_PER_SECOND = 64'd1000000;

  // one drive result as seen at the output
  typedef struct {
    logic [PORT_W-1:0] port;
    logic              drive_update;
    logic              reverse;
    logic [DUTY_W-1:0] duty;
  } drive_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  mts_cfg_idx_e            cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [PORT_W-1:0]       cmd_port;
  logic signed [THR_W-1:0] cmd_throttle;
  logic [TIME_W-1:0]       cmd_time;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PORT_W-1:0]       res_port;
  logic                    res_update;
  logic                    res_reverse;
  logic [DUTY_W-1:0]       res_duty;

  // predictor copy of the registers and the per-port ramp state
  logic [RATE_W-1:0] ramp_rate_q;
  logic [MASK_W-1:0] soft_mask_q;
  logic [MASK_W-1:0] normal_mask_q;
  int                setpoint_prev [PORT_COUNT];
  int                held_out      [PORT_COUNT];
  int                applied_out   [PORT_COUNT];
  bit                ramp_active   [PORT_COUNT];
  logic [TIME_W-1:0] last_step_us  [PORT_COUNT];

  drive_result_t pending_drives[$];
  bit            any_failure;

  // stimulus pacing
  int          burst_left;
  int          sender_gap_max;
  int          stall_pct;
  int          hold_off_left;
  logic [TIME_W-1:0]       port_clock  [PORT_COUNT];
  logic signed [THR_W-1:0] port_target [PORT_COUNT];

  motor_throttle_slew_limiter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .port_i         (cmd_port),
    .throttle_i     (cmd_throttle),
    .time_us_i      (cmd_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_port_o     (res_port),
    .drive_update_o (res_update),
    .reverse_o      (res_reverse),
    .duty_o         (res_duty)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("motor_throttle_slew_limiter test failed");
    $finish;
  end

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // direction and duty for an applied value
  function automatic drive_result_t driven(logic [PORT_W-1:0] p, int v);
    drive_result_t r;
    int d;
    d = magnitude(v) * 255 / 127;
    if (d > 255) d = 255;
    r.port         = p;
    r.drive_update = 1'b1;
    r.reverse      = (v > 0) ? 1'b0 : 1'b1;
    r.duty         = d[DUTY_W-1:0];
    return r;
  endfunction

  // expected drive for one command; updates the per-port ramp state
  function automatic drive_result_t predict_drive(logic [PORT_W-1:0] p,
                                                  logic signed [THR_W-1:0] thr_in,
                                                  logic [TIME_W-1:0] now);
    drive_result_t r;
    int thr;
    int old;
    int diff;
    int step;
    logic [TIME_W-1:0] dt;
    longint unsigned reach;
    longint unsigned quot;
    thr            = thr_in;
    r.port         = p;
    r.drive_update = 1'b0;
    r.reverse      = 1'b0;
    r.duty         = '0;
    // direct mode: throttle goes straight to the bridge
    if (!(normal_mask_q[p] && soft_mask_q[p])) return driven(p, thr);
    // setpoint change: small magnitude or sign reversal starts a ramp
    if (setpoint_prev[p] != thr) begin
      old = setpoint_prev[p];
      if (magnitude(old) <= SOFT_BAND || magnitude(thr) <= SOFT_BAND ||
          (thr > 0 && old < 0) || (thr < 0 && old > 0))
        ramp_active[p] = 1'b1;
      held_out[p]      = thr;
      setpoint_prev[p] = thr;
    end
    dt = now - last_step_us[p];
    if (ramp_active[p]) begin
      if (dt < MIN_GAP_US) return r;
      if (ramp_rate_q != '0) begin
        reach = 64'(ramp_rate_q) * 64'(dt);
        diff  = thr - applied_out[p];
        quot  = reach / US_PER_SECOND;
        if (quot > 255) quot = 255;
        step = int'(quot);
        if (diff > 0 && 64'(diff) * US_PER_SECOND > reach) begin
          held_out[p] = applied_out[p] + step;
        end else if (diff < 0 && 64'(-diff) * US_PER_SECOND > reach) begin
          held_out[p] = applied_out[p] - step;
        end else begin
          held_out[p]    = thr;
          ramp_active[p] = 1'b0;
        end
      end
      r = driven(p, held_out[p]);
    end else begin
      r = driven(p, thr);
    end
    applied_out[p]  = held_out[p];
    last_step_us[p] = now;
    return r;
  endfunction

  // register writes, result checks and predictions, all sampled at the rising edge
  always @(posedge clk_i) begin : monitor
    drive_result_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RAMP_RATE:   ramp_rate_q   = cfg_wdata[RATE_W-1:0];
          CFG_SOFT_START:  soft_mask_q   = cfg_wdata[MASK_W-1:0];
          CFG_NORMAL_MODE: normal_mask_q = cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_drives.size() == 0) begin
          $error("unexpected drive transaction for port %0d", res_port);
          any_failure = 1'b1;
        end else begin
          want = pending_drives.pop_front();
          if (res_port !== want.port) begin
            $error("out_port: expected %0d, got %0d", want.port, res_port);
            any_failure = 1'b1;
          end
          if (res_update !== want.drive_update) begin
            $error("drive_update: expected %0d, got %0d", want.drive_update, res_update);
            any_failure = 1'b1;
          end
          if (res_reverse !== want.reverse) begin
            $error("reverse: expected %0d, got %0d", want.reverse, res_reverse);
            any_failure = 1'b1;
          end
          if (res_duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, res_duty);
            any_failure = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_drives.push_back(predict_drive(cmd_port, cmd_throttle, cmd_time));
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // send one command transaction; called and returns at a falling edge
  task automatic send_cmd(input logic [PORT_W-1:0] p, input logic signed [THR_W-1:0] thr,
                          input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap        = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    cmd_port     <= p;
    cmd_throttle <= thr;
    cmd_time     <= t;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding drive result
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // write all three registers once the block is idle
  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [MASK_W-1:0] soft_bits,
                            input logic [MASK_W-1:0] normal);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    junk      = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RAMP_RATE;
    cfg_wdata <= rate;
    @(negedge clk_i);
    cfg_idx   <= CFG_SOFT_START;
    cfg_wdata <= {junk[CFG_DATA_W-1:MASK_W], soft_bits};
    @(negedge clk_i);
    cfg_idx   <= CFG_NORMAL_MODE;
    cfg_wdata <= {junk[CFG_DATA_W-1:MASK_W] ^ 12'hA5C, normal};
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // direct drive: zero, full scale both ways, saturation at -128, both mask cases
  task automatic test_direct_drive();
    sender_gap_max = 0;
    stall_pct      = 0;
    send_cmd(2'd0, 8'sd0, 32'd10);
    send_cmd(2'd1, 8'sd127, 32'd20);
    send_cmd(2'd2, -8'sd128, 32'd30);
    send_cmd(2'd3, -8'sd1, 32'hFFFF_FFFF);
    send_cmd(2'd0, 8'sd1, 32'd40);
    // soft start enabled but no port in normal mode
    set_config(16'd100, 4'hF, 4'h0);
    send_cmd(2'd1, -8'sd5, 32'd50);
    send_cmd(2'd2, 8'sd64, 32'd60);
  endtask

  // ramps: early update skipped, partial step, landing, reversal, timestamp wrap
  task automatic test_soft_start_ramp();
    set_config(16'd100, 4'hF, 4'hF);
    send_cmd(2'd0, 8'sd60, 32'd50000);
    send_cmd(2'd0, 8'sd60, 32'd200000);
    send_cmd(2'd0, 8'sd60, 32'd1200000);
    send_cmd(2'd1, 8'sd50, 32'd100000);
    send_cmd(2'd1, 8'sd50, 32'd10000000);
    send_cmd(2'd1, -8'sd50, 32'd10100000);
    send_cmd(2'd1, -8'sd90, 32'd30000000);
    send_cmd(2'd2, 8'sd100, 32'hFFFF_0000);
    send_cmd(2'd2, -8'sd100, 32'h0001_0000);
  endtask

  // zero rate holds the new setpoint without stepping; then the fastest and slowest rates
  task automatic test_rate_extremes();
    set_config(16'd0, 4'hF, 4'hF);
    send_cmd(2'd3, 8'sd80, 32'd500000);
    send_cmd(2'd3, 8'sd80, 32'd700000);
    set_config(16'hFFFF, 4'hF, 4'hF);
    send_cmd(2'd3, -8'sd128, 32'd900000);
    set_config(16'd1, 4'h5, 4'h7);
    send_cmd(2'd0, 8'sd7, 32'd3000000);
    send_cmd(2'd1, 8'sd33, 32'd3000000);
  endtask

  // next setpoint for a port: mostly small, large, reversed or extreme values
  function automatic logic signed [THR_W-1:0] pick_setpoint(logic signed [THR_W-1:0] cur);
    case ($urandom_range(0, 5))
      0: return $signed(THR_W'($urandom_range(0, 40) - 20));
      1: return $signed(THR_W'($urandom_range(21, 127)));
      2: return $signed(THR_W'(-$urandom_range(21, 128)));
      3: return (cur == -8'sd128) ? 8'sd127 : -cur;
      4: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      default: return $signed(THR_W'($urandom));
    endcase
  endfunction

  // time to the next command on a port, around the 100 ms update interval
  function automatic logic [TIME_W-1:0] pick_advance();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 99999);
      2: return $urandom_range(0, 1) ? 32'd99999 : 32'd100000;
      7: return $urandom_range(1000000, 3000000);
      8: return $urandom;
      default: return $urandom_range(100000, 400000);
    endcase
  endfunction

  // random phases: ramp sequences on random ports with some noise commands
  task automatic test_random_traffic();
    logic [PORT_W-1:0]       p;
    logic signed [THR_W-1:0] thr;
    logic [RATE_W-1:0]       rate;
    for (int i = 0; i < PORT_COUNT; i++) begin
      port_clock[i]  = $urandom;
      port_target[i] = THR_W'($urandom);
    end
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        set_config(16'd100, 4'hF, 4'hF);
        sender_gap_max = 0;
        stall_pct      = 0;
      end else begin
        case ($urandom_range(0, 5))
          0: rate = 16'd0;
          1: rate = 16'd1;
          2: rate = 16'd100;
          3: rate = 16'hFFFF;
          4: rate = RATE_W'($urandom_range(2, 1000));
          default: rate = RATE_W'($urandom);
        endcase
        set_config(rate, $urandom_range(0, 1) ? 4'hF : MASK_W'($urandom),
                   $urandom_range(0, 1) ? 4'hF : MASK_W'($urandom));
        sender_gap_max = $urandom_range(0, 8);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = PORT_W'($urandom_range(0, PORT_COUNT - 1));
        if ($urandom_range(0, 99) < 25) port_target[p] = pick_setpoint(port_target[p]);
        thr = ($urandom_range(0, 99) < 8) ? THR_W'($urandom) : port_target[p];
        port_clock[p] = port_clock[p] + pick_advance();
        send_cmd(p, thr, port_clock[p]);
      end
    end
  endtask

  // long receiver hold-off while commands keep coming, then a full pause and ten more commands
  task automatic test_backpressure();
    logic [PORT_W-1:0] p;
    set_config(16'd100, 4'hF, 4'hF);
    sender_gap_max = 0;
    stall_pct      = 30;
    @(posedge clk_i);
    hold_off_left = HOLD_OFF_LEN;
    @(negedge clk_i);
    for (int n = 0; n < 40; n++) begin
      p = PORT_W'(n % PORT_COUNT);
      port_clock[p] = port_clock[p] + pick_advance();
      send_cmd(p, pick_setpoint(port_target[p]), port_clock[p]);
    end
    wait_drained();
    for (int n = 0; n < 10; n++) begin
      p = PORT_W'($urandom_range(0, PORT_COUNT - 1));
      port_clock[p] = port_clock[p] + pick_advance();
      send_cmd(p, port_target[p], port_clock[p]);
    end
  endtask

  // reset, then the tests in turn
  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_RAMP_RATE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    cmd_port       = '0;
    cmd_throttle   = '0;
    cmd_time       = '0;
    any_failure    = 1'b0;
    burst_left     = 0;
    sender_gap_max = 0;
    stall_pct      = 0;
    hold_off_left  = 0;
    ramp_rate_q    = RATE_RESET;
    soft_mask_q    = SOFT_RESET;
    normal_mask_q  = NORMAL_RESET;
    for (int i = 0; i < PORT_COUNT; i++) begin
      setpoint_prev[i] = 0;
      held_out[i]      = 0;
      applied_out[i]   = 0;
      ramp_active[i]   = 1'b0;
      last_step_us[i]  = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_direct_drive();
    test_soft_start_ramp();
    test_rate_extremes();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    if (!any_failure) begin
      $display("motor_throttle_slew_limiter test passed");
    end else begin
      $display("motor_throttle_slew_limiter test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_state_mem.sv
rtl/mts_slew_pipe.sv
rtl/motor_throttle_slew_limiter.sv
dv/motor_throttle_slew_limiter_tb.sv
